>>> rtl/core/pgdw_pkg.sv
// ----------------------------------------------------------------------------
// pgdw_pkg
// shared widths, register indexes and the exp(-x) lookup table for the
// periodic gaussian dip waveform unit
// ----------------------------------------------------------------------------
package pgdw_pkg;

    // stream and register widths
    localparam int PHASE_BITS      = 16;
    localparam int FLUX_FRAC_BITS  = 15;
    localparam int FLUX_W          = FLUX_FRAC_BITS + 1;
    localparam int AMP_W           = 16;
    localparam int K_W             = 24;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 24;

    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(16384);
    localparam logic [K_W-1:0]   K_RESET   = K_W'(12800);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_AMPLITUDE        = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_TWO_WIDTH_SQ = CFG_ADDR_W'(1);

    // exp table: DEPTH+1 entries over x in [0,16], entries in Q.30
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int DEPTH_BITS      = $clog2(EXP_TABLE_DEPTH);
    localparam int ROM_W           = 31;
    localparam int FR_W            = 16;

    typedef logic [ROM_W-1:0] t_exp_rom [0:EXP_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // exp(-f) for f in Q.30, 0 <= f <= 1.0, truncating taylor series
    function automatic logic [63:0] exp_series(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = Q30_ONE;
        sum  = signed'(Q30_ONE);
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        return unsigned'(sum);
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] e1;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] v;
        e1 = exp_series(Q30_ONE);
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            t = (64'(i) << 34) >> DEPTH_BITS;
            n = t >> 30;
            v = exp_series(t & (Q30_ONE - 64'd1));
            for (int j = 0; j < 16; j++) begin
                if (64'(j) < n) begin
                    v = (v * e1) >> 30;
                end
            end
            rom[i] = ROM_W'(v);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

>>> rtl/core/periodic_gaussian_dip_waveform_unit.sv
// ----------------------------------------------------------------------------
// periodic_gaussian_dip_waveform_unit
// flux = 1 - A*exp(-p^2*K) - A*exp(-(1-p)^2*K), clamped at zero
// ----------------------------------------------------------------------------
// an accepted input beat passes through stages 0 to 6 in order to become its output beat
// throughput: one beat per cycle while the output is ready, set by the seven-stage pipeline
// each stage holds a valid bit, so bubbles fill up while the output stalls
// reset clears all valid bits and loads amplitude 0.5 and K 50.0
// ----------------------------------------------------------------------------
module periodic_gaussian_dip_waveform_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pgdw_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pgdw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pgdw_pkg::PHASE_BITS-1:0]     i_s_axis_tdata,  // phase_in
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [pgdw_pkg::FLUX_W-1:0]         o_m_axis_tdata,  // flux
    output logic                                o_m_axis_tuser   // clamped
);

    localparam int PB      = pgdw_pkg::PHASE_BITS;
    localparam int SQ_W    = 2 * PB + 1;
    localparam int SQ_FRAC = 2 * PB;
    localparam int X_W     = SQ_W + pgdw_pkg::K_W;
    localparam int X_FRAC  = SQ_FRAC + 8;
    localparam int DB      = pgdw_pkg::DEPTH_BITS;
    localparam int ROM_W   = pgdw_pkg::ROM_W;
    localparam int FR_W    = pgdw_pkg::FR_W;
    localparam int IDX_LO  = X_FRAC + 4 - DB;
    localparam int FR_LO   = X_FRAC - 12 - DB;
    localparam int MUL_W   = ROM_W + FR_W;
    localparam int ESUM_W  = ROM_W + 1;
    localparam int PROD_W  = pgdw_pkg::AMP_W + ESUM_W;
    localparam int OUT_SH  = 45 - pgdw_pkg::FLUX_FRAC_BITS;
    localparam int RND_W   = 46;
    localparam int NSTG    = 7;

    localparam logic [PB:0]                 PHASE_ONE = (PB+1)'(1) << PB;
    localparam logic [PROD_W-1:0]           RAW_ONE   = PROD_W'(1) << 45;
    localparam logic [RND_W-1:0]            RND_HALF  = RND_W'(1) << (OUT_SH - 1);
    localparam logic [pgdw_pkg::FLUX_W-1:0] FLUX_MAX  =
        pgdw_pkg::FLUX_W'(1) << pgdw_pkg::FLUX_FRAC_BITS;

    // configuration registers
    logic [pgdw_pkg::AMP_W-1:0] r_amp;
    logic [pgdw_pkg::K_W-1:0]   r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= pgdw_pkg::AMP_RESET;
            r_k   <= pgdw_pkg::K_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pgdw_pkg::CFG_AMPLITUDE:        r_amp <= i_cfg_wdata[pgdw_pkg::AMP_W-1:0];
                pgdw_pkg::CFG_INV_TWO_WIDTH_SQ: r_k   <= i_cfg_wdata[pgdw_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 0: squares of p and 1-p
    logic [PB:0]     w_q;
    logic [SQ_W-1:0] n_sq [2];
    logic [SQ_W-1:0] r_sq [2];

    assign w_q = PHASE_ONE - {1'b0, i_s_axis_tdata};

    always_comb begin
        n_sq[0] = SQ_W'(i_s_axis_tdata) * SQ_W'(i_s_axis_tdata);
        n_sq[1] = SQ_W'(w_q) * SQ_W'(w_q);
    end

    // stage 1: exponent argument x = square * K
    logic [X_W-1:0] r_x [2];

    // stage 2: table read
    logic [ROM_W-1:0] n_a [2];
    logic [ROM_W-1:0] n_d [2];
    logic [ROM_W-1:0] r_a [2];
    logic [ROM_W-1:0] r_d [2];
    logic [FR_W-1:0]  r_fr [2];
    logic [DB-1:0]    w_idx [2];
    logic [DB:0]      w_idx1 [2];
    logic [ROM_W-1:0] w_ta [2];
    logic [ROM_W-1:0] w_tb [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_idx[l]  = r_x[l][IDX_LO +: DB];
            w_idx1[l] = {1'b0, w_idx[l]} + (DB+1)'(1);
            w_ta[l]   = pgdw_pkg::EXP_ROM[w_idx[l]];
            w_tb[l]   = pgdw_pkg::EXP_ROM[w_idx1[l]];
            if (|r_x[l][X_W-1:X_FRAC+4]) begin
                n_a[l] = '0;
                n_d[l] = '0;
            end else if (w_ta[l] < w_tb[l]) begin
                n_a[l] = w_ta[l];
                n_d[l] = '0;
            end else begin
                n_a[l] = w_ta[l];
                n_d[l] = w_ta[l] - w_tb[l];
            end
        end
    end

    // stage 3: linear interpolation
    logic [MUL_W-1:0] w_mul [2];
    logic [ROM_W-1:0] n_e [2];
    logic [ROM_W-1:0] r_e [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_mul[l] = MUL_W'(r_d[l]) * MUL_W'(r_fr[l]);
            n_e[l]   = r_a[l] - ROM_W'(w_mul[l] >> FR_W);
        end
    end

    // stage 4: sum, stage 5: scale by amplitude
    logic [ESUM_W-1:0] r_esum;
    logic [PROD_W-1:0] r_prod;

    // stage 6: subtract from one, round and clamp
    logic                        w_neg;
    logic [RND_W-1:0]            w_rnd;
    logic [pgdw_pkg::FLUX_W-1:0] w_flux;
    logic [pgdw_pkg::FLUX_W-1:0] r_flux;
    logic                        r_clamp;

    always_comb begin
        w_neg  = r_prod > RAW_ONE;
        w_rnd  = RND_W'(RAW_ONE - r_prod) + RND_HALF;
        w_flux = pgdw_pkg::FLUX_W'(w_rnd >> OUT_SH);
        if (w_neg) begin
            w_flux = '0;
        end else if (w_flux > FLUX_MAX) begin
            w_flux = FLUX_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (w_en[0]) begin
                r_sq[l] <= n_sq[l];
            end
            if (w_en[1]) begin
                r_x[l] <= X_W'(r_sq[l]) * X_W'(r_k);
            end
            if (w_en[2]) begin
                r_a[l]  <= n_a[l];
                r_d[l]  <= n_d[l];
                r_fr[l] <= r_x[l][FR_LO +: FR_W];
            end
            if (w_en[3]) begin
                r_e[l] <= n_e[l];
            end
        end
        if (w_en[4]) begin
            r_esum <= ESUM_W'(r_e[0]) + ESUM_W'(r_e[1]);
        end
        if (w_en[5]) begin
            r_prod <= PROD_W'(r_amp) * PROD_W'(r_esum);
        end
        if (w_en[6]) begin
            r_flux  <= w_flux;
            r_clamp <= w_neg;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = r_flux;
    assign o_m_axis_tuser  = r_clamp;

    // checks
    a_clamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("clamped beat carries nonzero flux");

    a_flux_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata <= FLUX_MAX))
        else $error("flux above 1.0");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted beat lost at stage 0");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-2] && !w_en[NSTG-1]) |=> r_vld[NSTG-2])
        else $error("stalled beat dropped before output stage");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_e[0] <= ROM_W'(pgdw_pkg::Q30_ONE) &&
                      r_e[1] <= ROM_W'(pgdw_pkg::Q30_ONE)))
        else $error("interpolated exp above 1.0");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the periodic gaussian dip waveform unit: a table of
// probe phases under reset and extreme register settings, then random phases in
// several register settings, scored beat by beat against the typed table values
// or a local fixed-point flux calculation, with random idling and one long output stall
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PHASE_BITS     = pgdw_pkg::PHASE_BITS;
    localparam int FLUX_FRAC_BITS = pgdw_pkg::FLUX_FRAC_BITS;
    localparam int FLUX_W         = pgdw_pkg::FLUX_W;
    localparam int AMP_W          = pgdw_pkg::AMP_W;
    localparam int K_W            = pgdw_pkg::K_W;
    localparam int CFG_ADDR_W     = pgdw_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W     = pgdw_pkg::CFG_DATA_W;

    localparam int TAB_DEPTH   = 256;
    localparam int N_PROBES    = 22;
    localparam int N_SEGMENTS  = 6;
    localparam int SEG_BEATS   = 210;
    localparam int DUT_LATENCY = 7;

    typedef struct packed {
        logic [FLUX_W-1:0] flux;
        logic              clamped;
    } t_flux_beat;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] amp_word;
        logic [CFG_DATA_W-1:0] k_word;
        logic [PHASE_BITS-1:0] phase;
        logic                  typed;
        logic [FLUX_W-1:0]     flux;
        logic                  clamped;
    } t_probe_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PHASE_BITS-1:0] s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [FLUX_W-1:0]     m_tdata;
    logic                  m_tuser;

    logic [63:0]    exp_tab [0:TAB_DEPTH];
    logic [AMP_W-1:0] amp_reg;
    logic [K_W-1:0]   k_reg;
    t_flux_beat     flux_pending [$];
    t_probe_row     probes [N_PROBES];
    int             mismatch_count = 0;
    bit             quiet_run = 1'b0;
    bit             hold_req  = 1'b0;

    periodic_gaussian_dip_waveform_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // phase_in
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // flux
        .o_m_axis_tuser  (m_tuser)    // clamped
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // exp(-f), f in Q.30 within [0,1], truncating taylor series
    function automatic logic [63:0] exp_neg_series(input logic [63:0] f);
        logic [63:0] term;
        longint      acc;
        term = 64'd1 << 30;
        acc  = longint'(64'd1 << 30);
        for (int n = 1; n <= 24; n++) begin
            term = ((term * f) >> 30) / 64'(n);
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return 64'(acc);
    endfunction

    function automatic void build_exp_table();
        logic [63:0] e_one;
        logic [63:0] t;
        logic [63:0] v;
        e_one = exp_neg_series(64'd1 << 30);
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            t = (64'(i) << 34) / 64'(TAB_DEPTH);
            v = exp_neg_series(t & ((64'd1 << 30) - 64'd1));
            for (int j = 0; j < int'(t >> 30); j++) begin
                v = (v * e_one) >> 30;
            end
            exp_tab[i] = v & 64'hFFFF_FFFF;
        end
    endfunction

    // exp(-sq*K), sq with 32 fraction bits, result in Q.30
    function automatic logic [63:0] dip_exp(input logic [63:0] sq);
        logic [63:0] x;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] fr;
        logic [63:0] a;
        logic [63:0] b;
        x = sq * 64'(k_reg);
        if ((x >> 40) >= 64'd16) begin
            return 64'd0;
        end
        pos = (x >> 16) * 64'(TAB_DEPTH);
        idx = pos >> 28;
        fr  = (pos >> 12) & 64'hFFFF;
        if (idx >= 64'(TAB_DEPTH)) begin
            return 64'd0;
        end
        a = exp_tab[idx];
        b = exp_tab[idx + 1];
        if (a < b) begin
            return a;
        end
        return a - (((a - b) * fr) >> 16);
    endfunction

    function automatic t_flux_beat predict_flux(input logic [PHASE_BITS-1:0] ph);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] esum;
        logic [63:0] rounded;
        longint      raw;
        t_flux_beat  r;
        p    = 64'(ph);
        q    = (64'd1 << PHASE_BITS) - p;
        esum = dip_exp(p * p) + dip_exp(q * q);
        raw  = longint'(64'd1 << 45) - longint'(64'(amp_reg) * esum);
        if (raw < 0) begin
            r.flux    = '0;
            r.clamped = 1'b1;
        end else begin
            rounded = (64'(raw) + (64'd1 << (44 - FLUX_FRAC_BITS))) >> (45 - FLUX_FRAC_BITS);
            if (rounded > (64'd1 << FLUX_FRAC_BITS)) begin
                rounded = 64'd1 << FLUX_FRAC_BITS;
            end
            r.flux    = rounded[FLUX_W-1:0];
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    // the dip regions near both ends, uniform values, edge values and the middle
    function automatic logic [PHASE_BITS-1:0] pick_phase();
        int sel;
        sel = $urandom_range(9);
        case (sel) inside
            4, 5: begin
                return PHASE_BITS'($urandom_range(4095));
            end
            6, 7: begin
                return PHASE_BITS'(65535 - $urandom_range(4095));
            end
            8: begin
                case ($urandom_range(4))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'h7FFF;
                    3: return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
            9: begin
                return PHASE_BITS'(32768 - 2048 + $urandom_range(4095));
            end
            default: begin
                return PHASE_BITS'($urandom);
            end
        endcase
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == pgdw_pkg::CFG_AMPLITUDE) begin
            amp_reg = val[AMP_W-1:0];
        end else if (idx == pgdw_pkg::CFG_INV_TWO_WIDTH_SQ) begin
            k_reg = val[K_W-1:0];
        end
    endtask

    task automatic send_phase(input logic [PHASE_BITS-1:0] ph, input t_flux_beat want);
        @(negedge clk);
        while (!quiet_run && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ph;
        do begin
            @(posedge clk);
        end while (!s_tready);
        flux_pending.push_back(want);
    endtask

    task automatic settle_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (flux_pending.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // output side: random backpressure, or one long hold-off on request
    initial begin
        int held;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                for (held = 0; held < 300; held++) begin
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end else begin
                m_tready <= quiet_run || ($urandom_range(99) >= 9);
            end
        end
    end

    always @(posedge clk) begin : score
        t_flux_beat want;
        if (rst_n && m_tvalid && m_tready) begin
            if (flux_pending.size() == 0) begin
                log_mismatch("output beat with nothing pending", int'(m_tdata), -1);
            end else begin
                want = flux_pending.pop_front();
                if (m_tdata !== want.flux) begin
                    log_mismatch("flux", int'(m_tdata), int'(want.flux));
                end
                if (m_tuser !== want.clamped) begin
                    log_mismatch("clamped", int'(m_tuser), int'(want.clamped));
                end
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] amp_now;
        logic [CFG_DATA_W-1:0] k_now;
        logic [CFG_DATA_W-1:0] amp_word;
        logic [CFG_DATA_W-1:0] k_word;
        logic [PHASE_BITS-1:0] ph;
        t_flux_beat            want;

        build_exp_table();
        amp_reg = pgdw_pkg::AMP_RESET;
        k_reg   = pgdw_pkg::K_RESET;
        amp_now = CFG_DATA_W'(pgdw_pkg::AMP_RESET);
        k_now   = CFG_DATA_W'(pgdw_pkg::K_RESET);

        // amp, K, phase, typed, flux, clamped
        probes = '{
            '{24'd16384, 24'd12800, 16'h0000, 1'b0, 16'd0, 1'b0},
            '{24'd16384, 24'd12800, 16'h0001, 1'b0, 16'd0, 1'b0},
            '{24'd16384, 24'd12800, 16'h8000, 1'b0, 16'd0, 1'b0},
            '{24'd16384, 24'd12800, 16'hFFFF, 1'b0, 16'd0, 1'b0},
            '{24'd16384, 24'd12800, 16'h5555, 1'b0, 16'd0, 1'b0},
            '{24'd16384, 24'd12800, 16'hAAAA, 1'b0, 16'd0, 1'b0},
            '{24'd16384, 24'd12800, 16'h7FFF, 1'b0, 16'd0, 1'b0},
            // zero depth: flat at 1.0
            '{24'd0,     24'd12800, 16'h0000, 1'b1, 16'd32768, 1'b0},
            '{24'd0,     24'd12800, 16'hFFFF, 1'b1, 16'd32768, 1'b0},
            // upper write bits are dropped
            '{24'hFF4000, 24'd12800, 16'h0000, 1'b0, 16'd0, 1'b0},
            // K zero: both terms exactly one, raw lands on zero unflagged at amplitude 0.5
            '{24'h004000, 24'd0,    16'h0000, 1'b1, 16'd0, 1'b0},
            '{24'h004000, 24'd0,    16'h1234, 1'b1, 16'd0, 1'b0},
            '{24'd32768,  24'd0,    16'h8000, 1'b1, 16'd0, 1'b1},
            // depth above 1.0
            '{24'd65535,  24'd12800, 16'h0000, 1'b1, 16'd0, 1'b1},
            '{24'd65535,  24'd12800, 16'h8000, 1'b0, 16'd0, 1'b0},
            // widest K: exponent past the table everywhere but the ends, then K 2304
            '{24'd32768,  24'hFFFFFF, 16'h0000, 1'b1, 16'd0, 1'b0},
            '{24'd32768,  24'hFFFFFF, 16'h0001, 1'b0, 16'd0, 1'b0},
            '{24'd32768,  24'hFFFFFF, 16'h8000, 1'b1, 16'd32768, 1'b0},
            '{24'd32768,  24'hFFFFFF, 16'hFFFF, 1'b0, 16'd0, 1'b0},
            '{24'd32768,  24'd2304,  16'h8000, 1'b0, 16'd0, 1'b0},
            '{24'd32768,  24'd2304,  16'h4000, 1'b0, 16'd0, 1'b0},
            '{24'd32768,  24'd2304,  16'hC000, 1'b0, 16'd0, 1'b0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (probes[i]) begin
            if (probes[i].amp_word != amp_now || probes[i].k_word != k_now) begin
                settle_pipeline();
                if (probes[i].amp_word != amp_now) begin
                    write_reg(pgdw_pkg::CFG_AMPLITUDE, probes[i].amp_word);
                    amp_now = probes[i].amp_word;
                end
                if (probes[i].k_word != k_now) begin
                    write_reg(pgdw_pkg::CFG_INV_TWO_WIDTH_SQ, probes[i].k_word);
                    k_now = probes[i].k_word;
                end
            end
            if (probes[i].typed) begin
                want.flux    = probes[i].flux;
                want.clamped = probes[i].clamped;
            end else begin
                want = predict_flux(probes[i].phase);
            end
            send_phase(probes[i].phase, want);
        end

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            case (seg)
                0: begin
                    amp_word = CFG_DATA_W'(pgdw_pkg::AMP_RESET);
                    k_word   = CFG_DATA_W'(pgdw_pkg::K_RESET);
                end
                1: begin
                    amp_word = CFG_DATA_W'($urandom_range(32768, 1));
                    k_word   = CFG_DATA_W'($urandom_range(65535, 2304));
                end
                2: begin
                    amp_word = 24'd32768;
                    k_word   = 24'd2304;
                end
                3: begin
                    amp_word = 24'd1;
                    k_word   = 24'hFFFFFF;
                end
                4: begin
                    amp_word = CFG_DATA_W'($urandom);
                    k_word   = CFG_DATA_W'($urandom);
                end
                default: begin
                    amp_word = CFG_DATA_W'($urandom_range(32768, 1));
                    k_word   = CFG_DATA_W'($urandom_range(50000, 2304));
                end
            endcase
            settle_pipeline();
            write_reg(pgdw_pkg::CFG_AMPLITUDE, amp_word);
            write_reg(pgdw_pkg::CFG_INV_TWO_WIDTH_SQ, k_word);
            quiet_run = (seg == 2);
            hold_req  = (seg == 1);
            repeat (SEG_BEATS) begin
                ph = pick_phase();
                send_phase(ph, predict_flux(ph));
            end
        end

        settle_pipeline();
        repeat (DUT_LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pgdw_pkg.sv
rtl/core/periodic_gaussian_dip_waveform_unit.sv
bench/tb_top.sv
